// File: rtl/core/hdf_pkg.sv
// Package for the hash duplicate filter: payload structs, register
// addresses and sequencer states. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hdf_pkg;

  typedef struct packed {
    logic signed [63:0] a_value;
    logic [63:0]        b_value;
  } in_item_t;

  typedef struct packed {
    logic        is_duplicate;
    logic [15:0] slot_index;
    logic [15:0] probe_count;
    logic        table_full;
  } out_item_t;

  localparam int unsigned RegIdxW = 2;
  localparam logic [RegIdxW-1:0] REG_MULT_A     = 2'd0;
  localparam logic [RegIdxW-1:0] REG_MULT_B     = 2'd1;
  localparam logic [RegIdxW-1:0] REG_TABLE_SIZE = 2'd2;

  localparam logic [16:0] TableSizeReset = 17'd65521;
  localparam int unsigned FpShift = 32;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_MOD, ST_READ, ST_WAIT, ST_CHECK, ST_OUT
  } state_t;

  // Shared unit control between sequencer and arithmetic unit.
  typedef struct packed {
    logic start_mul;
    logic start_mod;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
  } alu_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/hdf_alu.sv
// Shared bit-serial arithmetic unit: shift-add multiply-accumulate for the
// hash, then restoring modulo by the slot count. Uses hdf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hdf_alu #(
  parameter int unsigned KW = 25
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire hdf_pkg::alu_ctl_t ctl,
  output hdf_pkg::alu_sts_t    sts,
  input  wire logic [63:0]     mult_a,
  input  wire logic [63:0]     mult_b,
  input  wire logic [63:0]     a_in,
  input  wire logic [63:0]     b_in,
  input  wire logic [KW-1:0]   k_in,
  output logic [63:0]          hash,
  output logic [KW-1:0]        rem
);
  import hdf_pkg::*;

  logic [6:0]   cnt;
  logic         mode_mod;
  logic         busy;
  logic [63:0]  opa, opb, ma, mb, acc;
  logic [63:0]  dvd;
  logic [KW:0]  rr;
  logic [KW:0]  rr_sh;
  logic [63:0]  acc_next;

  always_comb begin
    acc_next = acc;
    if (ma[0]) acc_next = acc_next + opa;
    if (mb[0]) acc_next = acc_next + opb;
    rr_sh = {rr[KW-1:0], dvd[63]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      mode_mod <= 1'b0;
    end else if (ctl.start_mul) begin
      busy <= 1'b1; cnt <= 7'd64; mode_mod <= 1'b0;
      opa <= a_in; opb <= b_in; ma <= mult_a; mb <= mult_b; acc <= '0;
    end else if (ctl.start_mod) begin
      busy <= 1'b1; cnt <= 7'd64; mode_mod <= 1'b1;
      dvd <= acc; rr <= '0;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
      if (!mode_mod) begin
        acc <= acc_next;
        opa <= opa << 1; opb <= opb << 1;
        ma <= ma >> 1;   mb <= mb >> 1;
      end else begin
        dvd <= dvd << 1;
        if (rr_sh >= {1'b0, k_in}) rr <= rr_sh - {1'b0, k_in};
        else rr <= rr_sh;
      end
    end
  end

  assign sts.busy = busy;
  assign hash = acc;
  assign rem  = rr[KW-1:0];
endmodule
`default_nettype wire

// File: rtl/core/hash_duplicate_filter.sv
// Hash duplicate filter top level: config registers, sequencer, table.
// Uses hdf_pkg and hdf_alu.
// Each item passes through a bit-serial multiply, a bit-serial modulo and
// one slot read per probe before out_valid; in_ready is low from input
// accept until the result is taken. Reset: registers to reset values, then
// a clear of every table entry.
`timescale 1ns / 1ps
`default_nettype none
module hash_duplicate_filter #(
  parameter int unsigned TABLE_DEPTH = 65536
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hdf_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hdf_pkg::out_item_t      out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  import hdf_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned KW = AW + 1;

  // Configuration registers.
  logic [63:0] mult_a, mult_b;
  logic [16:0] table_size;
  logic [RegIdxW-1:0] reg_idx;
  assign reg_idx = paddr[4:3];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mult_a <= 64'd1; mult_b <= 64'd1; table_size <= TableSizeReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_MULT_A:     mult_a <= pwdata;
        REG_MULT_B:     mult_b <= pwdata;
        REG_TABLE_SIZE: table_size <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (reg_idx)
        REG_MULT_A:     prdata = mult_a;
        REG_MULT_B:     prdata = mult_b;
        REG_TABLE_SIZE: prdata = {47'd0, table_size};
        default:        prdata = '0;
      endcase
    end
  end

  // Clamp slot count to 1..TABLE_DEPTH.
  logic [KW-1:0] k_eff;
  always_comb begin
    priority if (table_size == 17'd0) k_eff = KW'(1);
    else if (32'(table_size) > 32'(TABLE_DEPTH))
      k_eff = KW'(TABLE_DEPTH);
    else k_eff = KW'(table_size);
  end

  // Shared arithmetic unit.
  alu_ctl_t ctl;
  alu_sts_t sts;
  logic [63:0] hash;
  logic [KW-1:0] rem;
  in_item_t item;

  hdf_alu #(.KW(KW)) u_alu (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .mult_a(mult_a), .mult_b(mult_b),
    .a_in(item.a_value), .b_in(item.b_value), .k_in(k_eff),
    .hash(hash), .rem(rem)
  );

  // Fingerprint table.
  logic [31:0] mem [TABLE_DEPTH];
  logic [31:0] rd_data;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_wdata;
  logic        mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data <= mem[mem_addr];
  end

  state_t state, state_next;
  logic [KW-1:0] slot, home, steps, clr_cnt;
  logic [31:0] fp;
  logic hit_any, is_match;

  assign is_match = (rd_data == fp);
  assign hit_any  = (rd_data == 32'd0) || is_match;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == KW'(TABLE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_MUL;
      ST_MUL:   if (!sts.busy && !ctl.start_mul) state_next = ST_MOD;
      ST_MOD:   if (!sts.busy && !ctl.start_mod) state_next = ST_READ;
      ST_READ:  state_next = ST_WAIT;
      ST_WAIT:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (hit_any || steps + KW'(1) >= k_eff) state_next = ST_OUT;
        else state_next = ST_READ;
      end
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  logic mul_started, mod_started;
  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    ctl.start_mul = (state == ST_MUL) && !mul_started;
    ctl.start_mod = (state == ST_MOD) && !mod_started;
    mem_we = 1'b0;
    mem_wdata = fp;
    mem_addr = slot[AW-1:0];
    if (state == ST_CLEAR) begin
      mem_we = 1'b1; mem_wdata = '0; mem_addr = clr_cnt[AW-1:0];
    end else if (state == ST_CHECK && hit_any) begin
      mem_we = 1'b1;
    end
  end

  logic [KW-1:0] slot_inc;
  assign slot_inc = (slot + KW'(1) >= k_eff) ? '0 : slot + KW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      mul_started <= 1'b0;
      mod_started <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + KW'(1);
      mul_started <= (state == ST_MUL);
      mod_started <= (state == ST_MOD);
    end
  end

  // Datapath: capture item, hash results, advance probe.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) item <= in_data;
    if (state == ST_MOD && ctl.start_mod) fp <= hash[63:FpShift];
    if (state == ST_MOD && !sts.busy && !ctl.start_mod) begin
      home <= rem; slot <= rem; steps <= '0;
    end
    if (state == ST_CHECK) begin
      if (hit_any) begin
        out_data.is_duplicate <= is_match;
        out_data.slot_index   <= 16'(slot);
        out_data.probe_count  <= (steps > KW'(16'hFFFF)) ? 16'hFFFF : 16'(steps);
        out_data.table_full   <= 1'b0;
      end else if (steps + KW'(1) >= k_eff) begin
        out_data.is_duplicate <= (fp == 32'd0);
        out_data.slot_index   <= 16'(home);
        out_data.probe_count  <= (steps > KW'(16'hFFFF)) ? 16'hFFFF : 16'(steps);
        out_data.table_full   <= 1'b1;
      end else begin
        steps <= steps + KW'(1);
        slot  <= slot_inc;
      end
    end
  end
endmodule
`default_nettype wire

// File: tb/hash_duplicate_filter_tb.sv
// Self-checking testbench for hash_duplicate_filter: drives (a,b) pairs and
// checks each lookup result against a behavioral model of the probe table.
// Depends on hdf_pkg and the hash_duplicate_filter RTL.
`timescale 1ns / 1ps
module hash_duplicate_filter_tb;
  import hdf_pkg::*;

  localparam int unsigned Depth = 65536;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [4:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  hash_duplicate_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Model state: register copies and the fingerprint table.
  logic [63:0] mdl_mult_a;
  logic [63:0] mdl_mult_b;
  logic [16:0] mdl_table_size;
  logic [31:0] fp_store [0:Depth-1];

  out_item_t lookup_q [$];    // expected lookup results, oldest first
  in_item_t  pair_pool [$];   // recent pairs, replayed to provoke duplicates
  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned dup_seen;
  int unsigned full_seen;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned recv_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run time; covers the clearing pass plus the slowest run.
  initial begin
    #30_000_000;
    $display("hash_duplicate_filter_tb: FAIL");
    $display("timeout at %0t", $time);
    $finish;
  end

  // Work out one lookup and update the model table the way the block does.
  function automatic out_item_t predict_lookup(in_item_t it);
    out_item_t r;
    logic [63:0] h;
    logic [63:0] k;
    logic [63:0] home;
    logic [63:0] slot;
    logic [63:0] steps;
    logic [31:0] fp;
    logic hit;
    k = (mdl_table_size == 0) ? 64'd1 :
        (mdl_table_size > Depth) ? 64'(Depth) : 64'(mdl_table_size);
    h = mdl_mult_a * $unsigned(it.a_value) + mdl_mult_b * it.b_value;
    fp = h[63:32];
    home = h % k;
    slot = home;
    steps = 0;
    hit = 1'b0;
    while (steps < k && !hit) begin
      if (fp_store[slot] == 32'd0 || fp_store[slot] == fp) begin
        hit = 1'b1;
      end else begin
        steps++;
        slot = (slot + 1 >= k) ? 64'd0 : slot + 1;
      end
    end
    if (hit) begin
      r.is_duplicate = (fp_store[slot] == fp);
      fp_store[slot] = fp;
      r.slot_index = slot[15:0];
      r.probe_count = (steps > 64'hFFFF) ? 16'hFFFF : steps[15:0];
      r.table_full = 1'b0;
    end else begin
      // Every slot taken by some other fingerprint: report and store nothing.
      r.is_duplicate = (fp == 32'd0);
      r.slot_index = home[15:0];
      r.probe_count = (k - 1 > 64'hFFFF) ? 16'hFFFF : 16'(k - 1);
      r.table_full = 1'b1;
    end
    return r;
  endfunction

  // Offer one item, idling first at the current rate; valid stays high after.
  task automatic send_pair(input logic [63:0] a, input logic [63:0] b);
    in_item_t it;
    it.a_value = a;
    it.b_value = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lookup_q.insert(lookup_q.size(), predict_lookup(it));
    pair_pool.insert(pair_pool.size(), it);
    if (pair_pool.size() > 48) void'(pair_pool.pop_front());
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle. Only called when idle.
  task automatic reg_write(input logic [RegIdxW-1:0] idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MULT_A: mdl_mult_a = val;
      REG_MULT_B: mdl_mult_b = val;
      REG_TABLE_SIZE: mdl_table_size = val[16:0];
      default: ;  // unmapped index: the block ignores it
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] ma, input logic [63:0] mb,
                            input logic [63:0] size);
    reg_write(REG_MULT_A, ma);
    reg_write(REG_MULT_B, mb);
    reg_write(REG_TABLE_SIZE, size);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Reset values: small pairs hash below 2^32, so the fingerprint is zero.
  task automatic test_reset_defaults;
    send_pair(64'd0, 64'd0);
    send_pair(64'd5, 64'd7);
    send_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    send_pair(64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pair(64'h1234_5678_0000_0000, 64'd3);
    send_pair(64'h1234_5678_0000_0000, 64'd3);  // same pair again: duplicate
    drain();
  endtask

  // One slot: fill it, then collide into a full table, with and without fp 0.
  task automatic test_single_slot;
    set_config(64'd1, 64'd1, 64'd1);
    send_pair(64'hAAAA_0000_0000_0000, 64'd0);
    send_pair(64'h5555_0000_0000_0000, 64'd0);  // different fp: full
    send_pair(64'hAAAA_0000_0000_0000, 64'd0);  // same fp: duplicate
    send_pair(64'd9, 64'd1);                    // fp 0 against full table
    drain();
    reg_write(REG_TABLE_SIZE, 64'd0);           // acts as one slot
    send_pair(64'h5555_0000_0000_0000, 64'd1);
    send_pair(64'hAAAA_0000_0000_0000, 64'd1);
    drain();
  endtask

  // Multiplier extremes, the largest table and the unmapped register.
  task automatic test_extreme_mults;
    set_config(64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1_FFFF);
    reg_write(2'd3, 64'hDEAD_BEEF_0000_0001);
    send_pair(64'h8000_0000_0000_0000, 64'h0000_0001_0000_0000);
    send_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd65536);
    send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'd12345);
    send_pair(64'h8000_0000_0000_0000, 64'd0);
    send_pair(64'h8000_0000_0000_0000, 64'd99);  // b ignored: duplicate
    drain();
    set_config(64'd0, 64'd0, 64'd3);             // hash always zero
    send_pair(rand64(), rand64());
    drain();
  endtask

  // Random pairs over small and large tables; replay pairs for duplicates.
  task automatic test_random_tables(input int unsigned phases,
                                    input int unsigned per_phase);
    logic [63:0] sizes [10] = '{2, 3, 5, 7, 13, 31, 61, 127, 65521, 65536};
    int unsigned p;
    int unsigned n;
    in_item_t old;
    for (p = 0; p < phases; p++) begin
      set_config(($urandom_range(3) == 0) ? 64'd1 : rand64(),
                 ($urandom_range(3) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : rand64(),
                 sizes[$urandom_range(9)]);
      for (n = 0; n < per_phase; n++) begin
        if (pair_pool.size() != 0 && $urandom_range(99) < 30) begin
          old = pair_pool[$urandom_range(pair_pool.size() - 1)];
          send_pair(old.a_value, old.b_value);
        end else if ($urandom_range(99) < 8) begin
          send_pair(64'($urandom_range(255)), 64'($urandom_range(255)));
        end else begin
          send_pair(rand64(), rand64());
        end
      end
      drain();
    end
  endtask

  // Hold off the receiver for a long stretch while items keep coming.
  task automatic test_backpressure;
    int unsigned n;
    set_config(rand64(), rand64(), 64'd61);
    recv_hold_cycles = 3000;
    for (n = 0; n < 20; n++) send_pair(rand64(), rand64());
    drain();
  endtask

  // Receiver: check each accepted result and drive out_ready for next edge.
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (lookup_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, out_data);
      end else begin
        exp_r = lookup_q.pop_front();
        if (out_data.is_duplicate !== exp_r.is_duplicate ||
            out_data.slot_index !== exp_r.slot_index ||
            out_data.probe_count !== exp_r.probe_count ||
            out_data.table_full !== exp_r.table_full) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_data);
        end
        if (exp_r.is_duplicate) dup_seen++;
        if (exp_r.table_full) full_seen++;
      end
    end
    if (recv_hold_cycles != 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int unsigned i;
    int unsigned wait_cnt;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    dup_seen = 0;
    full_seen = 0;
    recv_hold_cycles = 0;
    send_idle_pct = 18;
    recv_stall_pct = 56;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mdl_mult_a = 64'd1;
    mdl_mult_b = 64'd1;
    mdl_table_size = TableSizeReset;
    for (i = 0; i < Depth; i++) fp_store[i] = 32'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_single_slot();
    test_extreme_mults();
    test_random_tables(7, 60);
    test_backpressure();
    send_idle_pct = 56;
    recv_stall_pct = 18;
    test_random_tables(7, 60);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_tables(7, 60);

    // Let any straggler show up as an unexpected result.
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (lookup_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (400) @(posedge clk);
    if (lookup_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, lookup_q.size());
    end
    $display("covered %0d items, %0d results (%0d duplicates, %0d table full)",
             items_sent, results_seen, dup_seen, full_seen);
    $display("over table sizes 0..131071 and multiplier extremes, %0d errors",
             errors);
    if (errors == 0) begin
      $display("hash_duplicate_filter_tb: PASS");
    end else begin
      $display("hash_duplicate_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
